// ===== src/tkd_pkg.sv =====
package tkd_pkg;

	// parameter defaults
	localparam int MAX_SEQ_BYTES_DEF = 64;
	localparam int MAX_ARGS_DEF      = 8;
	localparam int ARG_WIDTH_DEF     = 16;

	// byte codes
	localparam logic [7:0] BYTE_ESC   = 8'h1b;
	localparam logic [7:0] BYTE_DEL   = 8'h7f;
	localparam logic [7:0] BYTE_CR    = 8'h0d;
	localparam logic [7:0] BYTE_LF    = 8'h0a;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_CSI   = 8'h5b;
	localparam logic [7:0] BYTE_SS3   = 8'h4f;
	localparam logic [7:0] BYTE_TILDE = 8'h7e;

	localparam logic [2:0] MOD_NONE = 3'b000;
	localparam logic [2:0] MOD_ALT  = 3'b010;
	localparam logic [2:0] MOD_CTRL = 3'b100;

	typedef enum logic [2:0] {
		KIND_SYMBOL   = 3'd0,
		KIND_CHAR     = 3'd1,
		KIND_FUNC     = 3'd2,
		KIND_UNKNOWN  = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		SYM_BACKSPACE = 4'd0,
		SYM_TAB       = 4'd1,
		SYM_ENTER     = 4'd2,
		SYM_ESCAPE    = 4'd3,
		SYM_UP        = 4'd4,
		SYM_DOWN      = 4'd5,
		SYM_LEFT      = 4'd6,
		SYM_RIGHT     = 4'd7,
		SYM_HOME      = 4'd8,
		SYM_END       = 4'd9,
		SYM_INSERT    = 4'd10,
		SYM_DELETE    = 4'd11,
		SYM_PAGEUP    = 4'd12,
		SYM_PAGEDOWN  = 4'd13
	} sym_t;

	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		kind_t       key_kind;
		sym_t        symbol;
		logic [20:0] codepoint;
		logic [3:0]  function_number;
		logic [2:0]  modifiers;
		logic [7:0]  final_byte;
		logic [3:0]  arg_count;
		logic [15:0] first_arg;
		logic [15:0] second_arg;
	} res_t;

endpackage

// ===== src/tkd_key_in_if.sv =====
interface tkd_key_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] in_byte;

	modport source (output valid, output action, output in_byte, input ready);
	modport sink (input valid, input action, input in_byte, output ready);
endinterface

// ===== src/tkd_key_out_if.sv =====
interface tkd_key_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  key_kind;
	logic [3:0]  symbol;
	logic [20:0] codepoint;
	logic [3:0]  function_number;
	logic [2:0]  modifiers;
	logic [7:0]  final_byte;
	logic [3:0]  arg_count;
	logic [15:0] first_arg;
	logic [15:0] second_arg;

	modport source (output valid, output key_kind, output symbol, output codepoint,
		output function_number, output modifiers, output final_byte, output arg_count,
		output first_arg, output second_arg, input ready);
	modport sink (input valid, input key_kind, input symbol, input codepoint,
		input function_number, input modifiers, input final_byte, input arg_count,
		input first_arg, input second_arg, output ready);
endinterface

// ===== src/terminal_key_sequence_decoder_top.sv =====
// channel   dir  handshake      payload
// key_in    in   valid/ready    action, in_byte
// key_out   out  valid/ready    key_kind, symbol, codepoint, function_number,
//                               modifiers, final_byte, arg_count, first_arg, second_arg
//
// one request per cycle while key_out is not stalled; a key event passes the input register,
// then parser logic into the output register
// arst_n clears the parser state to idle and empties both pipeline stages
// a stalled key_out fills the output register and then its skid entry; key_in
// drops ready once the skid entry is full and a request waits in the input register
module terminal_key_sequence_decoder_top #(
	parameter int MAX_SEQ_BYTES = tkd_pkg::MAX_SEQ_BYTES_DEF,
	parameter int MAX_ARGS      = tkd_pkg::MAX_ARGS_DEF,
	parameter int ARG_WIDTH     = tkd_pkg::ARG_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tkd_key_in_if.sink    key_in,
	tkd_key_out_if.source key_out
);

	// input register stage
	logic           valid_s1;
	tkd_pkg::item_t item_s1;

	// parser result and output queue handshake
	logic           space;
	logic           advance;
	logic           emit;
	tkd_pkg::res_t  res;

	// the stage moves on whenever the output side has a free slot
	assign advance      = valid_s1 && space;
	assign key_in.ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			item_s1.action  <= key_in.action;
			item_s1.in_byte <= key_in.in_byte;
		end
	end

	// parser state machine: updates once per request leaving the input stage
	tkd_parser #(
		.MAX_SEQ_BYTES (MAX_SEQ_BYTES),
		.MAX_ARGS      (MAX_ARGS),
		.ARG_WIDTH     (ARG_WIDTH)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	// output register plus skid entry
	tkd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && emit),
		.push_data (res),
		.space     (space),
		.key_out   (key_out)
	);

endmodule

// ===== src/tkd_parser.sv =====
module tkd_parser #(
	parameter int MAX_SEQ_BYTES = tkd_pkg::MAX_SEQ_BYTES_DEF,
	parameter int MAX_ARGS      = tkd_pkg::MAX_ARGS_DEF,
	parameter int ARG_WIDTH     = tkd_pkg::ARG_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  tkd_pkg::item_t     item,
	output logic               emit,
	output tkd_pkg::res_t      res
);

	localparam int CW = $clog2(MAX_ARGS + 1);
	localparam int BW = $clog2(MAX_SEQ_BYTES + 1);
	localparam int AW = ARG_WIDTH;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_ESC  = 5'b00010,
		PH_SS3  = 5'b00100,
		PH_CSI  = 5'b01000,
		PH_UTF8 = 5'b10000
	} phase_t;

	phase_t          phase_q, phase_n;
	logic            alt_q, alt_n;
	logic [1:0]      utf8_rem_q, utf8_rem_n;
	logic [20:0]     char_acc_q, char_acc_n;
	logic [AW-1:0]   arg_one_q, arg_one_n;
	logic [AW-1:0]   arg_two_q, arg_two_n;
	logic            digits_pend_q, digits_pend_n;
	logic [CW-1:0]   args_seen_q, args_seen_n;
	logic [BW-1:0]   byte_cnt_q, byte_cnt_n;

	logic [7:0]      b;
	logic            clr, set_esc, set_utf8;

	// plain byte decode, shared by idle and escape phases
	logic            pb_emit;
	tkd_pkg::res_t   pb_res;
	logic [20:0]     pb_acc;
	logic [1:0]      pb_rem;
	logic [2:0]      pb_mods;
	logic [7:0]      ctrl_ch;

	// csi helpers
	logic [2:0]      csi_mod;
	logic [AW+3:0]   dig_sum;
	logic [AW-1:0]   dig_slot, dig_val;
	logic [AW-1:0]   tilde_v;
	logic [4:0]      tilde_s;
	logic [31:0]     a1_wide, a2_wide;
	logic [4:0]      cnt_wide;
	logic [CW-1:0]   seen_eff;
	logic            do_store;
	logic            lt_hit;
	tkd_pkg::sym_t   lt_sym;
	logic            tl_sym_hit;
	tkd_pkg::sym_t   tl_sym;
	logic [3:0]      tl_fn;

	assign b = item.in_byte;

	always_comb begin
		lt_hit = 1'b1;
		lt_sym = tkd_pkg::SYM_UP;
		case (b)
			8'h41: lt_sym = tkd_pkg::SYM_UP;
			8'h42: lt_sym = tkd_pkg::SYM_DOWN;
			8'h43: lt_sym = tkd_pkg::SYM_RIGHT;
			8'h44: lt_sym = tkd_pkg::SYM_LEFT;
			8'h46: lt_sym = tkd_pkg::SYM_END;
			8'h48: lt_sym = tkd_pkg::SYM_HOME;
			default: lt_hit = 1'b0;
		endcase
	end

	always_comb begin
		pb_mods  = phase_q == PH_ESC ? tkd_pkg::MOD_ALT : tkd_pkg::MOD_NONE;
		pb_emit  = 1'b1;
		pb_res   = '0;
		pb_acc   = '0;
		pb_rem   = '0;
		ctrl_ch  = b + 8'h40;
		if (ctrl_ch >= 8'h41 && ctrl_ch <= 8'h5a) begin
			ctrl_ch = ctrl_ch + 8'h20;
		end
		pb_res.modifiers = pb_mods;
		if (b == tkd_pkg::BYTE_CR || b == tkd_pkg::BYTE_LF) begin
			pb_res.symbol = tkd_pkg::SYM_ENTER;
		end else if (b == tkd_pkg::BYTE_TAB) begin
			pb_res.symbol = tkd_pkg::SYM_TAB;
		end else if (b == tkd_pkg::BYTE_DEL) begin
			pb_res.symbol = tkd_pkg::SYM_BACKSPACE;
		end else if (b < 8'h20) begin
			pb_res.key_kind  = tkd_pkg::KIND_CHAR;
			pb_res.codepoint = 21'(ctrl_ch);
			pb_res.modifiers = pb_mods | tkd_pkg::MOD_CTRL;
		end else if ((b & 8'he0) == 8'hc0) begin
			pb_emit = 1'b0;
			pb_acc  = 21'(b & 8'h1f);
			pb_rem  = 2'd1;
		end else if ((b & 8'hf0) == 8'he0) begin
			pb_emit = 1'b0;
			pb_acc  = 21'(b & 8'h0f);
			pb_rem  = 2'd2;
		end else if ((b & 8'hf8) == 8'hf0) begin
			pb_emit = 1'b0;
			pb_acc  = 21'(b & 8'h07);
			pb_rem  = 2'd3;
		end else begin
			pb_res.key_kind  = tkd_pkg::KIND_CHAR;
			pb_res.codepoint = 21'(b);
		end
	end

	// csi modifier from the second argument, tilde value lookup
	always_comb begin
		csi_mod = tkd_pkg::MOD_NONE;
		if (args_seen_q >= CW'(2) && arg_two_q >= AW'(2) && arg_two_q <= AW'(8)) begin
			csi_mod = arg_two_q[2:0] - 3'd1;
		end
		tilde_v = args_seen_q != '0 ? arg_one_q : '0;
		tilde_s = tilde_v < AW'(32) ? tilde_v[4:0] : 5'd31;
		tl_sym_hit = 1'b1;
		tl_sym     = tkd_pkg::SYM_HOME;
		tl_fn      = '0;
		case (tilde_s)
			5'd1, 5'd7: tl_sym = tkd_pkg::SYM_HOME;
			5'd2:       tl_sym = tkd_pkg::SYM_INSERT;
			5'd3:       tl_sym = tkd_pkg::SYM_DELETE;
			5'd4, 5'd8: tl_sym = tkd_pkg::SYM_END;
			5'd5:       tl_sym = tkd_pkg::SYM_PAGEUP;
			5'd6:       tl_sym = tkd_pkg::SYM_PAGEDOWN;
			5'd11, 5'd12, 5'd13, 5'd14, 5'd15: begin
				tl_sym_hit = 1'b0;
				tl_fn      = 4'(tilde_s - 5'd10);
			end
			5'd17, 5'd18, 5'd19, 5'd20, 5'd21: begin
				tl_sym_hit = 1'b0;
				tl_fn      = 4'(tilde_s - 5'd11);
			end
			5'd23, 5'd24: begin
				tl_sym_hit = 1'b0;
				tl_fn      = 4'(tilde_s - 5'd12);
			end
			default: tl_sym_hit = 1'b0;
		endcase
		a1_wide  = 32'(arg_one_q);
		a2_wide  = 32'(arg_two_q);
		cnt_wide = 5'(args_seen_q);
	end

	// argument slot update: value * 10 + digit, saturating
	always_comb begin
		dig_slot = seen_eff == CW'(1) ? arg_one_q : arg_two_q;
		dig_sum  = ((AW+4)'(dig_slot) << 3) + ((AW+4)'(dig_slot) << 1)
			+ (AW+4)'(b[3:0]);
		dig_val  = dig_sum > (AW+4)'({AW{1'b1}}) ? {AW{1'b1}} : dig_sum[AW-1:0];
	end

	always_comb begin
		phase_n       = phase_q;
		alt_n         = alt_q;
		utf8_rem_n    = utf8_rem_q;
		char_acc_n    = char_acc_q;
		arg_one_n     = arg_one_q;
		arg_two_n     = arg_two_q;
		digits_pend_n = digits_pend_q;
		args_seen_n   = args_seen_q;
		byte_cnt_n    = byte_cnt_q;
		emit          = 1'b0;
		res           = '0;
		clr           = 1'b0;
		set_esc       = 1'b0;
		set_utf8      = 1'b0;
		seen_eff      = args_seen_q;
		do_store      = 1'b0;

		if (item.action) begin
			// timeout: only a lone escape resolves
			if (phase_q == PH_ESC) begin
				clr        = 1'b1;
				emit       = 1'b1;
				res.symbol = tkd_pkg::SYM_ESCAPE;
			end
		end else begin
			unique case (phase_q)
				PH_ESC: begin
					if (b == tkd_pkg::BYTE_CSI) begin
						phase_n    = PH_CSI;
						byte_cnt_n = BW'(2);
					end else if (b == tkd_pkg::BYTE_SS3) begin
						phase_n    = PH_SS3;
						byte_cnt_n = BW'(2);
					end else begin
						clr = 1'b1;
						if (b == tkd_pkg::BYTE_ESC) begin
							emit          = 1'b1;
							res.symbol    = tkd_pkg::SYM_ESCAPE;
							res.modifiers = tkd_pkg::MOD_ALT;
						end else begin
							emit     = pb_emit;
							res      = pb_res;
							set_utf8 = !pb_emit;
						end
					end
				end
				PH_SS3: begin
					clr  = 1'b1;
					emit = 1'b1;
					if (b >= 8'h50 && b <= 8'h53) begin
						res.key_kind        = tkd_pkg::KIND_FUNC;
						res.function_number = 4'(b - 8'h4f);
					end else if (lt_hit) begin
						res.symbol = lt_sym;
					end else begin
						res.key_kind   = tkd_pkg::KIND_UNKNOWN;
						res.final_byte = b;
					end
				end
				PH_CSI: begin
					byte_cnt_n = byte_cnt_q + BW'(1);
					if (b >= 8'h40 && b <= 8'h7e) begin
						clr  = 1'b1;
						emit = 1'b1;
						res.modifiers = csi_mod;
						if (b == tkd_pkg::BYTE_TILDE && tl_fn != '0) begin
							res.key_kind        = tkd_pkg::KIND_FUNC;
							res.function_number = tl_fn;
						end else if (b == tkd_pkg::BYTE_TILDE && tl_sym_hit) begin
							res.symbol = tl_sym;
						end else if (b != tkd_pkg::BYTE_TILDE && lt_hit) begin
							res.symbol = lt_sym;
						end else begin
							res.key_kind   = tkd_pkg::KIND_UNKNOWN;
							res.modifiers  = tkd_pkg::MOD_NONE;
							res.final_byte = b;
							res.arg_count  = cnt_wide[3:0];
							res.first_arg  = a1_wide[15:0];
							res.second_arg = a2_wide[15:0];
						end
					end else begin
						if (b >= 8'h30 && b <= 8'h39) begin
							if (digits_pend_q) begin
								do_store = 1'b1;
							end else if (args_seen_q < CW'(MAX_ARGS)) begin
								seen_eff      = args_seen_q + CW'(1);
								args_seen_n   = seen_eff;
								digits_pend_n = 1'b1;
								do_store      = 1'b1;
							end
						end else if (digits_pend_q) begin
							digits_pend_n = 1'b0;
						end else if (args_seen_q < CW'(MAX_ARGS)) begin
							args_seen_n = args_seen_q + CW'(1);
						end
						if (do_store && seen_eff == CW'(1)) begin
							arg_one_n = dig_val;
						end
						if (do_store && seen_eff == CW'(2)) begin
							arg_two_n = dig_val;
						end
						if (byte_cnt_n >= BW'(MAX_SEQ_BYTES)) begin
							clr          = 1'b1;
							emit         = 1'b1;
							res.key_kind = tkd_pkg::KIND_OVERFLOW;
						end
					end
				end
				PH_UTF8: begin
					char_acc_n = {char_acc_q[14:0], b[5:0]};
					if (utf8_rem_q != '0) begin
						utf8_rem_n = utf8_rem_q - 2'd1;
					end
					if (utf8_rem_n == '0) begin
						clr           = 1'b1;
						emit          = 1'b1;
						res.key_kind  = tkd_pkg::KIND_CHAR;
						res.codepoint = char_acc_n;
						res.modifiers = alt_q ? tkd_pkg::MOD_ALT : tkd_pkg::MOD_NONE;
					end
				end
				default: begin
					clr = 1'b1;
					if (b == tkd_pkg::BYTE_ESC) begin
						set_esc = 1'b1;
					end else begin
						emit     = pb_emit;
						res      = pb_res;
						set_utf8 = !pb_emit;
					end
				end
			endcase
		end

		if (clr) begin
			phase_n       = PH_IDLE;
			alt_n         = 1'b0;
			utf8_rem_n    = '0;
			char_acc_n    = '0;
			arg_one_n     = '0;
			arg_two_n     = '0;
			digits_pend_n = 1'b0;
			args_seen_n   = '0;
			byte_cnt_n    = '0;
		end
		if (set_esc) begin
			phase_n    = PH_ESC;
			byte_cnt_n = BW'(1);
		end
		if (set_utf8) begin
			phase_n    = PH_UTF8;
			char_acc_n = pb_acc;
			utf8_rem_n = pb_rem;
			alt_n      = pb_mods == tkd_pkg::MOD_ALT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			alt_q         <= 1'b0;
			utf8_rem_q    <= '0;
			char_acc_q    <= '0;
			arg_one_q     <= '0;
			arg_two_q     <= '0;
			digits_pend_q <= 1'b0;
			args_seen_q   <= '0;
			byte_cnt_q    <= '0;
		end else if (step) begin
			phase_q       <= phase_n;
			alt_q         <= alt_n;
			utf8_rem_q    <= utf8_rem_n;
			char_acc_q    <= char_acc_n;
			arg_one_q     <= arg_one_n;
			arg_two_q     <= arg_two_n;
			digits_pend_q <= digits_pend_n;
			args_seen_q   <= args_seen_n;
			byte_cnt_q    <= byte_cnt_n;
		end
	end

endmodule

// ===== src/tkd_out_buf.sv =====
module tkd_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tkd_pkg::res_t         push_data,
	output logic                  space,
	tkd_key_out_if.source         key_out
);

	logic          head_valid_q, skid_valid_q;
	tkd_pkg::res_t head_q, skid_q;
	logic          pop;

	assign space = !skid_valid_q;
	assign pop   = head_valid_q && key_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!head_valid_q || pop) begin
				head_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			head_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (push) begin
			if (!head_valid_q || pop) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign key_out.valid           = head_valid_q;
	assign key_out.key_kind        = head_q.key_kind;
	assign key_out.symbol          = head_q.symbol;
	assign key_out.codepoint       = head_q.codepoint;
	assign key_out.function_number = head_q.function_number;
	assign key_out.modifiers       = head_q.modifiers;
	assign key_out.final_byte      = head_q.final_byte;
	assign key_out.arg_count       = head_q.arg_count;
	assign key_out.first_arg       = head_q.first_arg;
	assign key_out.second_arg      = head_q.second_arg;

endmodule
